/* rtl/gcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared widths, register indexes, control word layout and the microcode
// program of the coin change dispenser.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int COIN_SLOTS = 3;   // slots in use, 1 to SLOT_CAP
  localparam int SLOT_CAP   = 3;   // slots provided by the register file

  localparam int VAL_W  = 7;
  localparam int CNT_W  = 8;
  localparam int TOT_W  = 17;
  localparam int AMT_W  = 9;
  localparam int COST_W = 10;
  localparam int SLOT_W = 2;
  localparam int PAID_W = 6;
  localparam int PROD_W = CNT_W + VAL_W;
  localparam int PC_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [SLOT_W-1:0] SLOT_NUM  = SLOT_W'(COIN_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(COIN_SLOTS - 1);
  localparam logic [PAID_W-1:0] PAID_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_FULL  = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITEM_COST = 3'd6;

  // request and result codes
  localparam logic REQ_COIN     = 1'b0;
  localparam logic REQ_DISPENSE = 1'b1;
  localparam logic KIND_COIN    = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [SLOT_CAP-1:0][VAL_W-1:0] coin_value;
    logic [SLOT_CAP-1:0][CNT_W-1:0] start_count;
    logic [COST_W-1:0]              max_item_cost;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD_CLR,
    OP_LOAD_ACC,
    OP_LOAD_FLAG,
    OP_SLOT_CLR,
    OP_COIN,
    OP_CLAMP,
    OP_PAY,
    OP_STATUS
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_NOT_IDLE,
    COND_COIN_REQ,
    COND_SLOT_MORE,
    COND_PAY_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic accept;
    logic idle;
    logic coin_req;
    logic slot_last;
    logic pay_done;
    logic out_free;
  } dp_stat_t;

  // microcode addresses
  localparam logic [PC_W-1:0] UA_WAIT      = 4'd0;
  localparam logic [PC_W-1:0] UA_IDLE_CHK  = 4'd1;
  localparam logic [PC_W-1:0] UA_LOAD_CLR  = 4'd2;
  localparam logic [PC_W-1:0] UA_LOAD_ACC  = 4'd3;
  localparam logic [PC_W-1:0] UA_LOAD_FLAG = 4'd4;
  localparam logic [PC_W-1:0] UA_DISPATCH  = 4'd5;
  localparam logic [PC_W-1:0] UA_CLAMP     = 4'd6;
  localparam logic [PC_W-1:0] UA_PAY       = 4'd7;
  localparam logic [PC_W-1:0] UA_STATUS    = 4'd8;
  localparam logic [PC_W-1:0] UA_RETURN    = 4'd9;
  localparam logic [PC_W-1:0] UA_COIN      = 4'd10;
  localparam logic [PC_W-1:0] UA_COIN_END  = 4'd11;

  // Jump to target when the condition holds, otherwise fall through.
  function automatic cw_t ucode_rom(input logic [PC_W-1:0] pc);
    cw_t cw;
    unique case (pc)
      UA_WAIT:      cw = '{OP_ACCEPT,    COND_NO_ACCEPT, UA_WAIT};
      UA_IDLE_CHK:  cw = '{OP_NOP,       COND_NOT_IDLE,  UA_DISPATCH};
      UA_LOAD_CLR:  cw = '{OP_LOAD_CLR,  COND_NONE,      UA_WAIT};
      UA_LOAD_ACC:  cw = '{OP_LOAD_ACC,  COND_SLOT_MORE, UA_LOAD_ACC};
      UA_LOAD_FLAG: cw = '{OP_LOAD_FLAG, COND_NONE,      UA_WAIT};
      UA_DISPATCH:  cw = '{OP_SLOT_CLR,  COND_COIN_REQ,  UA_COIN};
      UA_CLAMP:     cw = '{OP_CLAMP,     COND_NONE,      UA_WAIT};
      UA_PAY:       cw = '{OP_PAY,       COND_PAY_MORE,  UA_PAY};
      UA_STATUS:    cw = '{OP_STATUS,    COND_OUT_BUSY,  UA_STATUS};
      UA_RETURN:    cw = '{OP_NOP,       COND_ALWAYS,    UA_WAIT};
      UA_COIN:      cw = '{OP_COIN,      COND_SLOT_MORE, UA_COIN};
      UA_COIN_END:  cw = '{OP_NOP,       COND_ALWAYS,    UA_STATUS};
      default:      cw = '{OP_NOP,       COND_ALWAYS,    UA_WAIT};
    endcase
    return cw;
  endfunction

endpackage

/* rtl/gcc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_cfg
// Configuration register file: coin values, start counts and the exact
// change threshold, written through a plain write port.
// ----------------------------------------------------------------------------
module gcc_cfg
  import gcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coin_value[0]  <= VAL_W'(25);
      cfg_r.coin_value[1]  <= VAL_W'(10);
      cfg_r.coin_value[2]  <= VAL_W'(5);
      cfg_r.start_count    <= '0;
      cfg_r.max_item_cost  <= COST_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COIN_VALUE_0:  cfg_r.coin_value[0]  <= cfg_data[VAL_W-1:0];
        CFG_COIN_VALUE_1:  cfg_r.coin_value[1]  <= cfg_data[VAL_W-1:0];
        CFG_COIN_VALUE_2:  cfg_r.coin_value[2]  <= cfg_data[VAL_W-1:0];
        CFG_START_COUNT_0: cfg_r.start_count[0] <= cfg_data[CNT_W-1:0];
        CFG_START_COUNT_1: cfg_r.start_count[1] <= cfg_data[CNT_W-1:0];
        CFG_START_COUNT_2: cfg_r.start_count[2] <= cfg_data[CNT_W-1:0];
        CFG_MAX_ITEM_COST: cfg_r.max_item_cost  <= cfg_data[COST_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/gcc_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_seq
// Microcode sequencer: step counter, control store lookup and conditional
// jump on datapath flags.
// ----------------------------------------------------------------------------
module gcc_seq
  import gcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output cw_t      cw
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign cw = ucode_rom(pc_r);

  always_comb begin
    unique case (cw.cond)
      COND_NONE:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_ACCEPT: take = !stat.accept;
      COND_NOT_IDLE:  take = !stat.idle;
      COND_COIN_REQ:  take = stat.coin_req;
      COND_SLOT_MORE: take = !stat.slot_last;
      COND_PAY_MORE:  take = !stat.pay_done;
      COND_OUT_BUSY:  take = !stat.out_free;
      default:        take = 1'b1;
    endcase
    pc_nxt = take ? cw.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UA_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* rtl/gcc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_dp
// Datapath: coin counts, running total, payout remainder, exact change flag,
// one slot pointer shared by every slot walk, and the result register.
// ----------------------------------------------------------------------------
module gcc_dp
  import gcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             cfg_we,
  input  cw_t              cw,
  output dp_stat_t         stat,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [AMT_W-1:0] in_amount,
  input  logic             in_is_coin,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [1:0]       out_slot,
  output logic             out_exact_change,
  output logic             out_flag_changed,
  output logic             out_last
);

  // control state
  logic idle_r;
  logic out_valid_r;

  // payload state
  logic [SLOT_CAP-1:0][CNT_W-1:0] cnt_r;
  logic [TOT_W-1:0]               total_r;
  logic [AMT_W-1:0]               rest_r;
  logic [PAID_W-1:0]              paid_r;
  logic [SLOT_W-1:0]              slot_r;
  logic                           flag_r;
  logic                           req_r;
  logic [AMT_W-1:0]               amount_r;
  logic                           is_coin_r;
  logic                           out_kind_r;
  logic [SLOT_W-1:0]              out_slot_r;
  logic                           out_exact_r;
  logic                           out_changed_r;

  logic              accept;
  logic              out_free;
  logic [VAL_W-1:0]  cur_val;
  logic [CNT_W-1:0]  cur_cnt;
  logic [PROD_W-1:0] prod;
  logic              new_flag;
  logic              can_pay;
  logic              pay_done;
  logic              coin_hit;
  logic [AMT_W-1:0]  clamp;
  logic              emit_coin;
  logic              emit_status;

  always_comb begin
    accept   = in_valid && (cw.op == OP_ACCEPT);
    out_free = !out_valid_r || !out_stall;
    cur_val  = (slot_r < SLOT_NUM) ? cfg.coin_value[slot_r] : '0;
    cur_cnt  = (slot_r < SLOT_NUM) ? cnt_r[slot_r] : '0;
    prod     = PROD_W'(cur_cnt) * PROD_W'(cur_val);
    new_flag = total_r <= TOT_W'(cfg.max_item_cost);
    can_pay  = (cur_val != '0) && (AMT_W'(cur_val) <= rest_r) && (cur_cnt != '0);
    pay_done = (rest_r == '0) || (paid_r == PAID_MAX) || (slot_r == SLOT_NUM);
    coin_hit = is_coin_r && (AMT_W'(cur_val) == amount_r) && (cur_cnt != CNT_FULL);
    clamp    = (TOT_W'(amount_r) > total_r) ? total_r[AMT_W-1:0] : amount_r;
    emit_coin   = (cw.op == OP_PAY) && !pay_done && can_pay && out_free;
    emit_status = (cw.op == OP_STATUS) && out_free;
  end

  assign stat = '{
    accept:    accept,
    idle:      idle_r,
    coin_req:  req_r == REQ_COIN,
    slot_last: slot_r == SLOT_LAST,
    pay_done:  pay_done,
    out_free:  out_free
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        idle_r <= 1'b1;
      end else if (cw.op == OP_LOAD_FLAG) begin
        idle_r <= 1'b0;
      end
      if (emit_coin || emit_status) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_ACCEPT: begin
        if (accept) begin
          req_r     <= in_req_type;
          amount_r  <= in_amount;
          is_coin_r <= in_is_coin;
        end
      end
      OP_LOAD_CLR: begin
        cnt_r   <= cfg.start_count;
        total_r <= '0;
        slot_r  <= '0;
      end
      OP_LOAD_ACC: begin
        total_r <= total_r + TOT_W'(prod);
        slot_r  <= slot_r + SLOT_W'(1);
      end
      OP_LOAD_FLAG: begin
        flag_r <= new_flag;
      end
      OP_SLOT_CLR: begin
        slot_r <= '0;
      end
      OP_COIN: begin
        if (coin_hit) begin
          cnt_r[slot_r] <= cur_cnt + CNT_W'(1);
          total_r       <= total_r + TOT_W'(cur_val);
        end
        slot_r <= slot_r + SLOT_W'(1);
      end
      OP_CLAMP: begin
        rest_r  <= clamp;
        total_r <= total_r - TOT_W'(clamp);
        slot_r  <= '0;
        paid_r  <= '0;
      end
      OP_PAY: begin
        if (!pay_done) begin
          if (can_pay) begin
            // hold while the result register is full and stalled
            if (out_free) begin
              rest_r        <= rest_r - AMT_W'(cur_val);
              cnt_r[slot_r] <= cur_cnt - CNT_W'(1);
              paid_r        <= paid_r + PAID_W'(1);
              out_kind_r    <= KIND_COIN;
              out_slot_r    <= slot_r;
              out_exact_r   <= 1'b0;
              out_changed_r <= 1'b0;
            end
          end else begin
            slot_r <= slot_r + SLOT_W'(1);
          end
        end
      end
      OP_STATUS: begin
        if (out_free) begin
          flag_r        <= new_flag;
          out_kind_r    <= KIND_STATUS;
          out_slot_r    <= '0;
          out_exact_r   <= new_flag;
          out_changed_r <= new_flag ^ flag_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall         = cw.op != OP_ACCEPT;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_slot         = out_slot_r;
  assign out_exact_change = out_exact_r;
  assign out_flag_changed = out_changed_r;
  assign out_last         = out_kind_r;   // the status beat closes every item

endmodule

/* rtl/greedy_coin_change_dispenser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_coin_change_dispenser_top
// Coin change dispenser with greedy payout, run by a microcode sequencer.
// ----------------------------------------------------------------------------
// One item is handled at a time; the input stalls from acceptance until the
// status beat has been loaded into the result register and the sequencer has
// passed its return step back to the wait step. A dispense item pays at most
// 63 coins, and payout and status wait while the result register is stalled.
// The first item after reset or after any register write first reloads the
// slot counts and recomputes the total through one multiplier, one slot per
// cycle. Payout runs from slot 0 upward, one coin beat per cycle while the
// result register is not stalled, and every item ends in one status beat
// carrying the exact change flag and whether it changed.
// ----------------------------------------------------------------------------
module greedy_coin_change_dispenser_top
  import gcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [AMT_W-1:0]      in_amount,
  input  logic                  in_is_coin,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [1:0]            out_slot,
  output logic                  out_exact_change,
  output logic                  out_flag_changed,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  cw_t      cw;
  dp_stat_t stat;

  gcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gcc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  gcc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cfg_we           (cfg_we),
    .cw               (cw),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_amount        (in_amount),
    .in_is_coin       (in_is_coin),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_exact_change (out_exact_change),
    .out_flag_changed (out_flag_changed),
    .out_last         (out_last)
  );

endmodule

/* rtl/gcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_checker
// Port-level checks on the dispenser, bound to the top level.
// ----------------------------------------------------------------------------
module gcc_checker
  import gcc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_kind,
  input logic [1:0]            out_slot,
  input logic                  out_exact_change,
  input logic                  out_flag_changed,
  input logic                  out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_slot)
      && $stable(out_exact_change) && $stable(out_flag_changed) && $stable(out_last))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: input stalls right after an accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  // coin beats carry a real slot and no status bits
  a_coin_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_COIN |-> !out_last && !out_exact_change
      && !out_flag_changed && out_slot != 2'd3)
    else $error("malformed coin beat");

  // status beat closes the item and points at slot zero
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_last && out_slot == 2'd0)
    else $error("malformed status beat");

endmodule

bind greedy_coin_change_dispenser_top gcc_checker u_gcc_checker (.*);

/* sim/greedy_coin_change_dispenser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_coin_change_dispenser_top_tb
// Self-checking bench for the coin change dispenser. A cycle-free predictor
// keeps its own slot counts, cash total and exact change flag. It queues the
// coin and status beats that each accepted request should produce. A checker
// compares every result beat field by field. Directed tests cover the reset
// setting, full and duplicate slots, the payout limit, zero-value and unsorted
// slots, the out of range register and flag changes. Random phases then run
// under fresh settings, most with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module greedy_coin_change_dispenser_top_tb;
  import gcc_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PAYOUT_MAX    = 63;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [1:0] slot;
    logic       exact_change;
    logic       flag_changed;
    logic       last;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = REQ_COIN;
  logic [AMT_W-1:0]      in_amount = '0;
  logic                  in_is_coin = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_kind;
  logic [1:0]            out_slot;
  logic                  out_exact_change;
  logic                  out_flag_changed;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state and its copy of the registers
  logic [VAL_W-1:0]  slot_value [SLOT_CAP];
  logic [CNT_W-1:0]  slot_fill  [SLOT_CAP];
  logic [COST_W-1:0] cost_limit;
  logic [CNT_W-1:0]  slot_count [SLOT_CAP];
  logic [TOT_W-1:0]  cash_total;
  logic              exact_only;
  logic              reload_due;

  beat_t pending_beats [$];
  int    err_count   = 0;
  int    cycle_count = 0;
  bit    quiet       = 1'b0;
  bit    long_hold   = 1'b0;

  greedy_coin_change_dispenser_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_amount        (in_amount),
    .in_is_coin       (in_is_coin),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_exact_change (out_exact_change),
    .out_flag_changed (out_flag_changed),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void reload_slots();
    cash_total = '0;
    for (int i = 0; i < SLOT_CAP; i++) slot_count[i] = '0;
    for (int i = 0; i < COIN_SLOTS; i++) begin
      slot_count[i] = slot_fill[i];
      cash_total    = cash_total + TOT_W'(slot_count[i]) * TOT_W'(slot_value[i]);
    end
    exact_only = (cash_total <= TOT_W'(cost_limit));
    reload_due = 1'b0;
  endfunction

  function automatic void reset_settings();
    slot_value[0] = 7'd25;
    slot_value[1] = 7'd10;
    slot_value[2] = 7'd5;
    for (int i = 0; i < SLOT_CAP; i++) slot_fill[i] = '0;
    cost_limit = 10'd100;
    reload_slots();
    reload_due = 1'b1;
  endfunction

  function automatic void predict_payout(input logic req, input logic [AMT_W-1:0] amt,
                                         input logic coin);
    logic             was_exact;
    logic [TOT_W-1:0] rest;
    int               paid;
    beat_t            b;
    if (reload_due) reload_slots();
    was_exact = exact_only;
    paid      = 0;
    if (req == REQ_COIN) begin
      if (coin) begin
        for (int i = 0; i < COIN_SLOTS; i++) begin
          if ({2'b00, slot_value[i]} == amt && slot_count[i] != CNT_FULL) begin
            slot_count[i]++;
            cash_total = cash_total + TOT_W'(slot_value[i]);
          end
        end
      end
    end else begin
      rest       = (TOT_W'(amt) > cash_total) ? cash_total : TOT_W'(amt);
      cash_total = cash_total - rest;
      for (int i = 0; i < COIN_SLOTS; i++) begin
        if (slot_value[i] != '0) begin
          while (rest >= TOT_W'(slot_value[i]) && slot_count[i] != '0
                 && paid < PAYOUT_MAX) begin
            rest = rest - TOT_W'(slot_value[i]);
            slot_count[i]--;
            b = '{KIND_COIN, 2'(i), 1'b0, 1'b0, 1'b0};
            pending_beats = {pending_beats, b};
            paid++;
          end
        end
      end
    end
    exact_only = (cash_total <= TOT_W'(cost_limit));
    b = '{KIND_STATUS, 2'd0, exact_only, exact_only != was_exact, 1'b1};
    pending_beats = {pending_beats, b};
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d slot %0d", out_kind, out_slot);
        err_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          err_count++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, out_slot);
          err_count++;
        end
        if (out_exact_change !== want.exact_change) begin
          $error("exact_change: expected %0d, actual %0d", want.exact_change,
                 out_exact_change);
          err_count++;
        end
        if (out_flag_changed !== want.flag_changed) begin
          $error("flag_changed: expected %0d, actual %0d", want.flag_changed,
                 out_flag_changed);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  // ----------------------------------------------------------------- receiver
  initial begin
    int hold;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        hold      = LONG_HOLD;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ------------------------------------------------------------------- sender
  task automatic send_item(input logic req, input logic [AMT_W-1:0] amt, input logic coin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_amount   <= amt;
    in_is_coin  <= coin;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_payout(req, amt, coin);
  endtask

  // drop valid and wait for every queued beat, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_COIN_VALUE_0:  slot_value[0] = data[VAL_W-1:0];
      CFG_COIN_VALUE_1:  slot_value[1] = data[VAL_W-1:0];
      CFG_COIN_VALUE_2:  slot_value[2] = data[VAL_W-1:0];
      CFG_START_COUNT_0: slot_fill[0]  = data[CNT_W-1:0];
      CFG_START_COUNT_1: slot_fill[1]  = data[CNT_W-1:0];
      CFG_START_COUNT_2: slot_fill[2]  = data[CNT_W-1:0];
      CFG_MAX_ITEM_COST: cost_limit    = data;
      default: ;
    endcase
    reload_due = 1'b1;
  endtask

  task automatic write_slots(input logic [CFG_DATA_W-1:0] v0, input logic [CFG_DATA_W-1:0] v1,
                             input logic [CFG_DATA_W-1:0] v2, input logic [CNT_W-1:0] c0,
                             input logic [CNT_W-1:0] c1, input logic [CNT_W-1:0] c2,
                             input logic [COST_W-1:0] cost);
    cfg_write(CFG_COIN_VALUE_0, v0);
    cfg_write(CFG_COIN_VALUE_1, v1);
    cfg_write(CFG_COIN_VALUE_2, v2);
    cfg_write(CFG_START_COUNT_0, CFG_DATA_W'(c0));
    cfg_write(CFG_START_COUNT_1, CFG_DATA_W'(c1));
    cfg_write(CFG_START_COUNT_2, CFG_DATA_W'(c2));
    cfg_write(CFG_MAX_ITEM_COST, cost);
  endtask

  // ------------------------------------------------------------------- tests
  task automatic test_reset_setting();
    send_item(REQ_DISPENSE, 9'd0, 1'b0);
    send_item(REQ_COIN, 9'd25, 1'b0);       // paper: status only
    send_item(REQ_COIN, 9'd25, 1'b1);
    send_item(REQ_COIN, 9'd10, 1'b1);
    send_item(REQ_COIN, 9'd5, 1'b1);
    send_item(REQ_COIN, 9'd7, 1'b1);        // matches no slot
    send_item(REQ_DISPENSE, 9'd40, 1'b1);
    send_item(REQ_DISPENSE, 9'h1FF, 1'b0);  // clamped to what is left
    drain();
  endtask

  task automatic test_full_and_limit();
    // duplicate values, both full; upper data bits must be masked off
    write_slots(10'h3E4, 10'd100, 10'd5, 8'd255, 8'd255, 8'd0, 10'h3FF);
    send_item(REQ_COIN, 9'd100, 1'b1);
    send_item(REQ_COIN, 9'd5, 1'b1);
    send_item(REQ_DISPENSE, 9'h1FF, 1'b1);  // leaves an unpayable remainder
    drain();
    write_slots(10'd5, 10'h385, 10'd5, 8'd255, 8'd255, 8'd255, 10'd0);
    send_item(REQ_DISPENSE, 9'h1FF, 1'b0);  // hits the payout cap
    send_item(REQ_DISPENSE, 9'h1FF, 1'b1);
    drain();
  endtask

  task automatic test_odd_slots();
    // zero-value slot first, then values in ascending order
    write_slots(10'h380, 10'd5, 10'h07F, 8'd7, 8'd4, 8'd1, 10'd300);
    send_item(REQ_DISPENSE, 9'd200, 1'b0);
    send_item(REQ_COIN, 9'd0, 1'b1);
    send_item(REQ_COIN, 9'd127, 1'b1);
    drain();
    cfg_write(CFG_UNUSED, 10'h3FF);         // ignored, but forces a reload
    send_item(REQ_DISPENSE, 9'd0, 1'b1);
    drain();
    cfg_write(CFG_MAX_ITEM_COST, 10'd146);
    send_item(REQ_COIN, 9'd5, 1'b0);
    send_item(REQ_DISPENSE, 9'd1, 1'b0);    // drops total to the threshold
    drain();
  endtask

  task automatic test_backpressure();
    write_slots(10'd25, 10'd10, 10'd5, 8'd20, 8'd20, 8'd20, 10'd100);
    long_hold = 1'b1;
    quiet     = 1'b1;
    for (int i = 0; i < 6; i++) send_item(REQ_DISPENSE, 9'd45, 1'b0);
    quiet = 1'b0;
    drain();
  endtask

  task automatic random_setting();
    logic [VAL_W-1:0]  v [3];
    logic [CNT_W-1:0]  c [3];
    logic [VAL_W-1:0]  t;
    for (int i = 0; i < 3; i++) begin
      v[i] = VAL_W'($urandom_range(5, 100));
      if ($urandom_range(0, 7) == 0) v[i] = $urandom_range(0, 1) ? 7'd0 : 7'h7F;
      c[i] = CNT_W'($urandom_range(0, 30));
      if ($urandom_range(0, 7) == 0) c[i] = CNT_FULL;
    end
    // mostly descending, as the slots are meant to be
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2 - i; j++)
          if (v[j] < v[j+1]) begin
            t = v[j]; v[j] = v[j+1]; v[j+1] = t;
          end
    end
    write_slots({3'($urandom), v[0]}, {3'($urandom), v[1]}, {3'($urandom), v[2]},
                c[0], c[1], c[2], COST_W'($urandom_range(0, 1023)));
  endtask

  task automatic run_random_items(input int n);
    int               roll;
    logic [AMT_W-1:0] amt;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        amt = {2'b00, slot_value[$urandom_range(0, COIN_SLOTS - 1)]};
        send_item(REQ_COIN, amt, $urandom_range(0, 9) != 0);
      end else if (roll < 55) begin
        send_item(1'($urandom), AMT_W'($urandom), 1'($urandom));
      end else begin
        amt = (roll < 90) ? AMT_W'($urandom_range(0, 120)) : AMT_W'($urandom_range(0, 511));
        send_item(REQ_DISPENSE, amt, 1'($urandom));
      end
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      random_setting();
      quiet = (phase == 2);
      run_random_items(50);
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    reset_settings();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_setting();
    test_full_and_limit();
    test_odd_slots();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
